/* rtl/pfa_pkg.sv */
package pfa_pkg;

  localparam int PAGE_COUNT_DEF  = 4096;
  localparam int CACHE_DEPTH_DEF = 64;

  localparam int PAGE_W  = 12;
  localparam int LEVEL_W = 13;
  localparam int MARK_W  = 6;
  localparam int RES_W   = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [MARK_W-1:0] LOW_MARK_RST  = 6'd8;
  localparam logic [MARK_W-1:0] HIGH_MARK_RST = 6'd32;
  localparam logic [MARK_W-1:0] BATCH_RST     = 6'd16;
  localparam logic [RES_W-1:0]  LOW_RES_RST   = 13'h10;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_SEED  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_BAD      = 2'd2;
  localparam logic [1:0] ST_RESERVED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_MARK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MARK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_RES   = 2'd3;

  typedef struct packed {
    logic [1:0]        mode;
    logic [PAGE_W-1:0] page_number;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0]  page_given;
    logic [1:0]         status;
    logic [LEVEL_W-1:0] free_level;
    logic [LEVEL_W-1:0] cached_level;
    logic [LEVEL_W-1:0] used_level;
  } rsp_t;

  // datapath operations, one per microstep
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE        = 4'd0;
  localparam logic [OP_W-1:0] OP_CLEAR_WR    = 4'd1;
  localparam logic [OP_W-1:0] OP_MOVED_ZERO  = 4'd2;
  localparam logic [OP_W-1:0] OP_REFILL      = 4'd3;
  localparam logic [OP_W-1:0] OP_POP         = 4'd4;
  localparam logic [OP_W-1:0] OP_MARK_USED   = 4'd5;
  localparam logic [OP_W-1:0] OP_FREE_CLEAR  = 4'd6;
  localparam logic [OP_W-1:0] OP_PUSH_GLOBAL = 4'd7;
  localparam logic [OP_W-1:0] OP_PUSH_CACHE  = 4'd8;
  localparam logic [OP_W-1:0] OP_SEED_COMMIT = 4'd9;
  localparam logic [OP_W-1:0] OP_SET_STATUS  = 4'd10;
  localparam logic [OP_W-1:0] OP_EMIT        = 4'd11;

  // jump conditions
  localparam int COND_W = 4;
  localparam logic [COND_W-1:0] C_ALWAYS       = 4'd0;
  localparam logic [COND_W-1:0] C_NO_IN        = 4'd1;
  localparam logic [COND_W-1:0] C_MODE_ALLOC   = 4'd2;
  localparam logic [COND_W-1:0] C_MODE_FREE    = 4'd3;
  localparam logic [COND_W-1:0] C_MODE_SEED    = 4'd4;
  localparam logic [COND_W-1:0] C_FILL_NOT_LOW = 4'd5;
  localparam logic [COND_W-1:0] C_REFILL_DONE  = 4'd6;
  localparam logic [COND_W-1:0] C_CACHE_EMPTY  = 4'd7;
  localparam logic [COND_W-1:0] C_PG_OOR       = 4'd8;
  localparam logic [COND_W-1:0] C_USED_ONE     = 4'd9;
  localparam logic [COND_W-1:0] C_PAGE_OOR     = 4'd10;
  localparam logic [COND_W-1:0] C_USED_ZERO    = 4'd11;
  localparam logic [COND_W-1:0] C_CACHE_ROOM   = 4'd12;
  localparam logic [COND_W-1:0] C_RESERVED     = 4'd13;
  localparam logic [COND_W-1:0] C_OUT_FREE     = 4'd14;
  localparam logic [COND_W-1:0] C_CLR_BUSY     = 4'd15;

  // program addresses
  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] S_CLR     = 5'd0;
  localparam logic [PC_W-1:0] S_IDLE    = 5'd1;
  localparam logic [PC_W-1:0] S_D_ALLOC = 5'd2;
  localparam logic [PC_W-1:0] S_D_FREE  = 5'd3;
  localparam logic [PC_W-1:0] S_D_SEED  = 5'd4;
  localparam logic [PC_W-1:0] S_D_NONE  = 5'd5;
  localparam logic [PC_W-1:0] S_A0      = 5'd6;
  localparam logic [PC_W-1:0] S_A1      = 5'd7;
  localparam logic [PC_W-1:0] S_A2      = 5'd8;
  localparam logic [PC_W-1:0] S_APOP    = 5'd9;
  localparam logic [PC_W-1:0] S_AP1     = 5'd10;
  localparam logic [PC_W-1:0] S_AP2     = 5'd11;
  localparam logic [PC_W-1:0] S_AP3     = 5'd12;
  localparam logic [PC_W-1:0] S_AP4     = 5'd13;
  localparam logic [PC_W-1:0] S_F0      = 5'd14;
  localparam logic [PC_W-1:0] S_F1      = 5'd15;
  localparam logic [PC_W-1:0] S_F2      = 5'd16;
  localparam logic [PC_W-1:0] S_F3      = 5'd17;
  localparam logic [PC_W-1:0] S_F4      = 5'd18;
  localparam logic [PC_W-1:0] S_S0      = 5'd19;
  localparam logic [PC_W-1:0] S_S1      = 5'd20;
  localparam logic [PC_W-1:0] S_S2      = 5'd21;
  localparam logic [PC_W-1:0] S_S3      = 5'd22;
  localparam logic [PC_W-1:0] S_BAD     = 5'd23;
  localparam logic [PC_W-1:0] S_RES     = 5'd24;
  localparam logic [PC_W-1:0] S_EMPTY   = 5'd25;
  localparam logic [PC_W-1:0] S_EMIT    = 5'd26;
  localparam logic [PC_W-1:0] S_EMIT_W  = 5'd27;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
    logic              use_pg;
    logic [1:0]        stat;
    logic              accept;
  } ctl_t;

  typedef struct packed {
    logic no_in;
    logic mode_alloc;
    logic mode_free;
    logic mode_seed;
    logic fill_not_low;
    logic refill_done;
    logic cache_empty;
    logic pg_oor;
    logic used_one;
    logic page_oor;
    logic used_zero;
    logic cache_room;
    logic reserved;
    logic out_free;
    logic clr_busy;
  } flags_t;

  function automatic ctl_t cw(input logic [OP_W-1:0] op, input logic [COND_W-1:0] cond,
                              input logic [PC_W-1:0] target, input logic use_pg,
                              input logic [1:0] stat, input logic accept);
    ctl_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.use_pg = use_pg;
    w.stat   = stat;
    w.accept = accept;
    return w;
  endfunction

  // control store: on a true condition jump to target, else step to the next word
  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t w;
    case (pc)
      S_CLR:     w = cw(OP_CLEAR_WR,    C_CLR_BUSY,     S_CLR,    1'b0, ST_OK, 1'b0);
      S_IDLE:    w = cw(OP_NONE,        C_NO_IN,        S_IDLE,   1'b0, ST_OK, 1'b1);
      S_D_ALLOC: w = cw(OP_NONE,        C_MODE_ALLOC,   S_A0,     1'b0, ST_OK, 1'b0);
      S_D_FREE:  w = cw(OP_NONE,        C_MODE_FREE,    S_F0,     1'b0, ST_OK, 1'b0);
      S_D_SEED:  w = cw(OP_NONE,        C_MODE_SEED,    S_S0,     1'b0, ST_OK, 1'b0);
      S_D_NONE:  w = cw(OP_NONE,        C_ALWAYS,       S_EMIT,   1'b0, ST_OK, 1'b0);
      S_A0:      w = cw(OP_MOVED_ZERO,  C_FILL_NOT_LOW, S_APOP,   1'b0, ST_OK, 1'b0);
      S_A1:      w = cw(OP_NONE,        C_REFILL_DONE,  S_APOP,   1'b0, ST_OK, 1'b0);
      S_A2:      w = cw(OP_REFILL,      C_ALWAYS,       S_A1,     1'b0, ST_OK, 1'b0);
      S_APOP:    w = cw(OP_NONE,        C_CACHE_EMPTY,  S_EMPTY,  1'b0, ST_OK, 1'b0);
      S_AP1:     w = cw(OP_POP,         C_ALWAYS,       S_AP2,    1'b0, ST_OK, 1'b0);
      S_AP2:     w = cw(OP_NONE,        C_PG_OOR,       S_BAD,    1'b1, ST_OK, 1'b0);
      S_AP3:     w = cw(OP_NONE,        C_USED_ONE,     S_BAD,    1'b1, ST_OK, 1'b0);
      S_AP4:     w = cw(OP_MARK_USED,   C_ALWAYS,       S_EMIT,   1'b1, ST_OK, 1'b0);
      S_F0:      w = cw(OP_NONE,        C_PAGE_OOR,     S_BAD,    1'b0, ST_OK, 1'b0);
      S_F1:      w = cw(OP_NONE,        C_USED_ZERO,    S_BAD,    1'b0, ST_OK, 1'b0);
      S_F2:      w = cw(OP_FREE_CLEAR,  C_CACHE_ROOM,   S_F4,     1'b0, ST_OK, 1'b0);
      S_F3:      w = cw(OP_PUSH_GLOBAL, C_ALWAYS,       S_EMIT,   1'b0, ST_OK, 1'b0);
      S_F4:      w = cw(OP_PUSH_CACHE,  C_ALWAYS,       S_EMIT,   1'b0, ST_OK, 1'b0);
      S_S0:      w = cw(OP_NONE,        C_PAGE_OOR,     S_BAD,    1'b0, ST_OK, 1'b0);
      S_S1:      w = cw(OP_NONE,        C_RESERVED,     S_RES,    1'b0, ST_OK, 1'b0);
      S_S2:      w = cw(OP_NONE,        C_USED_ZERO,    S_BAD,    1'b0, ST_OK, 1'b0);
      S_S3:      w = cw(OP_SEED_COMMIT, C_ALWAYS,       S_EMIT,   1'b0, ST_OK, 1'b0);
      S_BAD:     w = cw(OP_SET_STATUS,  C_ALWAYS,       S_EMIT,   1'b0, ST_BAD, 1'b0);
      S_RES:     w = cw(OP_SET_STATUS,  C_ALWAYS,       S_EMIT,   1'b0, ST_RESERVED, 1'b0);
      S_EMPTY:   w = cw(OP_SET_STATUS,  C_ALWAYS,       S_EMIT,   1'b0, ST_EMPTY, 1'b0);
      S_EMIT:    w = cw(OP_EMIT,        C_OUT_FREE,     S_IDLE,   1'b0, ST_OK, 1'b0);
      S_EMIT_W:  w = cw(OP_NONE,        C_ALWAYS,       S_EMIT,   1'b0, ST_OK, 1'b0);
      default:   w = cw(OP_NONE,        C_ALWAYS,       S_IDLE,   1'b0, ST_OK, 1'b0);
    endcase
    return w;
  endfunction

endpackage

/* rtl/page_frame_allocator_with_cache.sv */
// Channel  Dir  Handshake            Payload
// req      in   req_valid/req_ready  pfa_pkg::req_t  {mode, page_number}
// rsp      out  rsp_valid/rsp_ready  pfa_pkg::rsp_t  {page_given, status, levels}
// cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data (register write)
//
// One transaction at a time, stepped by a microcoded sequencer. An allocate
// that finds the cache below its low mark first refills it from the global
// stack, one page at a time (one global-stack read, then one cache write).
// After reset a clearing pass sets every used bit, one page a cycle; no
// request is taken until it ends, configuration is.
// A result waits in the output register; a stalled rsp holds the sequencer
// at its emit step until the previous result has gone, and the next request
// can be taken at the edge after the result is loaded.
module page_frame_allocator_with_cache #(
  parameter int PAGE_COUNT  = pfa_pkg::PAGE_COUNT_DEF,
  parameter int CACHE_DEPTH = pfa_pkg::CACHE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  pfa_pkg::req_t                    req,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output pfa_pkg::rsp_t                    rsp,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pfa_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int UA = $clog2(PAGE_COUNT);        // page-indexed memory address
  localparam int TW = $clog2(PAGE_COUNT + 1);    // global top / used count
  localparam int CA = $clog2(CACHE_DEPTH);
  localparam int FW = $clog2(CACHE_DEPTH + 1);

  // configuration
  logic [pfa_pkg::MARK_W-1:0] low_mark;
  logic [pfa_pkg::MARK_W-1:0] high_mark;
  logic [pfa_pkg::MARK_W-1:0] batch;
  logic [pfa_pkg::RES_W-1:0]  low_reserved;

  // state
  logic [TW-1:0]                top;
  logic [FW-1:0]                fill;
  logic [TW-1:0]                used_total;
  logic [UA-1:0]                clr_cnt;
  logic [pfa_pkg::MARK_W-1:0]   moved;

  // per-transaction working registers
  logic [1:0]                   mode;
  logic [pfa_pkg::PAGE_W-1:0]   page;
  logic [pfa_pkg::PAGE_W-1:0]   pg;
  logic [1:0]                   status;
  logic [pfa_pkg::PAGE_W-1:0]   given;

  pfa_pkg::ctl_t   ctl;
  pfa_pkg::flags_t flags;

  logic                         out_free;
  logic                         g_full;

  // memory ports
  logic                         u_we;
  logic [UA-1:0]                u_addr;
  logic                         u_wdata;
  logic                         used_rd;
  logic                         g_we;
  logic [pfa_pkg::PAGE_W-1:0]   g_rdata;
  logic                         c_we;
  logic [pfa_pkg::PAGE_W-1:0]   c_wdata;
  logic [pfa_pkg::PAGE_W-1:0]   c_rdata;

  assign cfg_ready = 1'b1;
  assign req_ready = ctl.accept;
  assign out_free  = !rsp_valid || rsp_ready;
  assign g_full    = (top == TW'(PAGE_COUNT));

  pfa_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  // condition flags for the sequencer
  always_comb begin
    flags.no_in        = !req_valid;
    flags.mode_alloc   = (mode == pfa_pkg::MODE_ALLOC);
    flags.mode_free    = (mode == pfa_pkg::MODE_FREE);
    flags.mode_seed    = (mode == pfa_pkg::MODE_SEED);
    flags.fill_not_low = (32'(fill) >= 32'(low_mark));
    flags.refill_done  = (moved >= batch) || (top == '0) || (fill == FW'(CACHE_DEPTH));
    flags.cache_empty  = (fill == '0);
    flags.pg_oor       = (32'(pg) >= PAGE_COUNT);
    flags.used_one     = used_rd;
    flags.page_oor     = (32'(page) >= PAGE_COUNT);
    flags.used_zero    = !used_rd;
    flags.cache_room   = (32'(fill) < 32'(high_mark)) && (fill < FW'(CACHE_DEPTH));
    flags.reserved     = ({1'b0, page} < low_reserved);
    flags.out_free     = out_free;
    flags.clr_busy     = (clr_cnt != UA'(PAGE_COUNT - 1));
  end

  // used bits: the clearing pass owns the port, else the request page or the popped page
  always_comb begin
    if (ctl.op == pfa_pkg::OP_CLEAR_WR) begin
      u_addr = clr_cnt;
    end else if (ctl.use_pg) begin
      u_addr = UA'(pg);
    end else begin
      u_addr = UA'(page);
    end
    u_we    = (ctl.op == pfa_pkg::OP_CLEAR_WR) || (ctl.op == pfa_pkg::OP_MARK_USED) ||
              (ctl.op == pfa_pkg::OP_FREE_CLEAR) || (ctl.op == pfa_pkg::OP_SEED_COMMIT);
    u_wdata = (ctl.op == pfa_pkg::OP_CLEAR_WR) || (ctl.op == pfa_pkg::OP_MARK_USED);
  end

  // push to the global stack is dropped when it is full
  assign g_we = ((ctl.op == pfa_pkg::OP_PUSH_GLOBAL) || (ctl.op == pfa_pkg::OP_SEED_COMMIT))
                && !g_full;

  assign c_we    = (ctl.op == pfa_pkg::OP_REFILL) || (ctl.op == pfa_pkg::OP_PUSH_CACHE);
  assign c_wdata = (ctl.op == pfa_pkg::OP_REFILL) ? g_rdata : page;

  pfa_ram #(.WIDTH(1), .DEPTH(PAGE_COUNT)) u_used (
    .clk   (clk),
    .we    (u_we),
    .waddr (u_addr),
    .wdata (u_wdata),
    .raddr (u_addr),
    .rdata (used_rd)
  );

  // global stack: read always looks at the top entry
  pfa_ram #(.WIDTH(pfa_pkg::PAGE_W), .DEPTH(PAGE_COUNT)) u_gstk (
    .clk   (clk),
    .we    (g_we),
    .waddr (UA'(top)),
    .wdata (page),
    .raddr (UA'(top - TW'(1))),
    .rdata (g_rdata)
  );

  pfa_ram #(.WIDTH(pfa_pkg::PAGE_W), .DEPTH(CACHE_DEPTH)) u_cstk (
    .clk   (clk),
    .we    (c_we),
    .waddr (CA'(fill)),
    .wdata (c_wdata),
    .raddr (CA'(fill - FW'(1))),
    .rdata (c_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      low_mark     <= pfa_pkg::LOW_MARK_RST;
      high_mark    <= pfa_pkg::HIGH_MARK_RST;
      batch        <= pfa_pkg::BATCH_RST;
      low_reserved <= pfa_pkg::LOW_RES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pfa_pkg::CFG_LOW_MARK:  low_mark     <= cfg_data[pfa_pkg::MARK_W-1:0];
        pfa_pkg::CFG_HIGH_MARK: high_mark    <= cfg_data[pfa_pkg::MARK_W-1:0];
        pfa_pkg::CFG_BATCH:     batch        <= cfg_data[pfa_pkg::MARK_W-1:0];
        pfa_pkg::CFG_LOW_RES:   low_reserved <= cfg_data;
        default:                low_reserved <= low_reserved;
      endcase
    end
  end

  // control state: stacks, counters, clearing pass, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      top        <= '0;
      fill       <= '0;
      used_total <= '0;
      clr_cnt    <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      // load a new result when the slot frees up, else drop valid once taken
      if ((ctl.op == pfa_pkg::OP_EMIT) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (ctl.op)
        pfa_pkg::OP_CLEAR_WR: begin
          clr_cnt <= clr_cnt + 1'b1;
        end
        pfa_pkg::OP_REFILL: begin
          top  <= top - 1'b1;
          fill <= fill + 1'b1;
        end
        pfa_pkg::OP_POP: begin
          fill <= fill - 1'b1;
        end
        pfa_pkg::OP_MARK_USED: begin
          used_total <= used_total + 1'b1;
        end
        pfa_pkg::OP_FREE_CLEAR: begin
          // a page used since reset may be freed without an allocation: saturate
          if (used_total != '0) begin
            used_total <= used_total - 1'b1;
          end
        end
        pfa_pkg::OP_PUSH_GLOBAL, pfa_pkg::OP_SEED_COMMIT: begin
          if (!g_full) begin
            top <= top + 1'b1;
          end
        end
        pfa_pkg::OP_PUSH_CACHE: begin
          fill <= fill + 1'b1;
        end
        default: begin
          top <= top;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      mode   <= req.mode;
      page   <= req.page_number;
      status <= pfa_pkg::ST_OK;
      given  <= '0;
    end
    case (ctl.op)
      pfa_pkg::OP_MOVED_ZERO: moved  <= '0;
      pfa_pkg::OP_REFILL:     moved  <= moved + 1'b1;
      pfa_pkg::OP_POP:        pg     <= c_rdata;
      pfa_pkg::OP_MARK_USED:  given  <= pg;
      pfa_pkg::OP_SET_STATUS: status <= ctl.stat;
      pfa_pkg::OP_EMIT: begin
        if (out_free) begin
          rsp.page_given   <= given;
          rsp.status       <= status;
          rsp.free_level   <= pfa_pkg::LEVEL_W'(top);
          rsp.cached_level <= pfa_pkg::LEVEL_W'(fill);
          rsp.used_level   <= pfa_pkg::LEVEL_W'(used_total);
        end
      end
      default: begin
        moved <= moved;
      end
    endcase
  end

  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == pfa_pkg::OP_CLEAR_WR) |-> !req_ready)
    else $error("request taken during the clearing pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second request taken before the first finished");

  a_refill_has_page: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == pfa_pkg::OP_REFILL) |-> (top != '0) && (fill < FW'(CACHE_DEPTH)))
    else $error("refill moved from an empty global stack or into a full cache");

  a_pop_has_page: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == pfa_pkg::OP_POP) |-> (fill != '0))
    else $error("pop from an empty cache");

endmodule

/* rtl/pfa_ram.sv */
module pfa_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/pfa_seq.sv */
module pfa_seq (
  input  logic            clk,
  input  logic            rst,
  input  pfa_pkg::flags_t flags,
  output pfa_pkg::ctl_t   ctl
);

  logic [pfa_pkg::PC_W-1:0] pc;
  logic [pfa_pkg::PC_W-1:0] pc_next;
  logic                     hit;

  assign ctl = pfa_pkg::ucode(pc);

  always_comb begin
    case (ctl.cond)
      pfa_pkg::C_ALWAYS:       hit = 1'b1;
      pfa_pkg::C_NO_IN:        hit = flags.no_in;
      pfa_pkg::C_MODE_ALLOC:   hit = flags.mode_alloc;
      pfa_pkg::C_MODE_FREE:    hit = flags.mode_free;
      pfa_pkg::C_MODE_SEED:    hit = flags.mode_seed;
      pfa_pkg::C_FILL_NOT_LOW: hit = flags.fill_not_low;
      pfa_pkg::C_REFILL_DONE:  hit = flags.refill_done;
      pfa_pkg::C_CACHE_EMPTY:  hit = flags.cache_empty;
      pfa_pkg::C_PG_OOR:       hit = flags.pg_oor;
      pfa_pkg::C_USED_ONE:     hit = flags.used_one;
      pfa_pkg::C_PAGE_OOR:     hit = flags.page_oor;
      pfa_pkg::C_USED_ZERO:    hit = flags.used_zero;
      pfa_pkg::C_CACHE_ROOM:   hit = flags.cache_room;
      pfa_pkg::C_RESERVED:     hit = flags.reserved;
      pfa_pkg::C_OUT_FREE:     hit = flags.out_free;
      pfa_pkg::C_CLR_BUSY:     hit = flags.clr_busy;
      default:                 hit = 1'b1;
    endcase
  end

  assign pc_next = hit ? ctl.target : pfa_pkg::PC_W'(pc + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= pfa_pkg::S_CLR;
    end else begin
      pc <= pc_next;
    end
  end

  // the program never runs off its last word
  a_pc_in_program: assert property (@(posedge clk) disable iff (rst)
    pc <= pfa_pkg::S_EMIT_W)
    else $error("sequencer left the control store");

endmodule
